### sv/sizstr_pkg.sv
// Package for the size string converter: widths, character codes, status
// codes, sequencer states and the unit letter decode.
// No dependencies.
package sizstr_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int OUT_W          = 64;
  localparam int CHAR_W         = 8;
  localparam int STATUS_W       = 2;
  localparam int BASE_W         = 16;
  localparam int DIGIT_W        = 4;
  localparam int SCALE_W        = 3;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int REG_IDX_W      = APB_ADDR_W - 2;
  localparam int DEC_BASE       = 10;

  localparam logic [BASE_W-1:0]    UNIT_BASE_RESET = 16'd1024;
  localparam logic [REG_IDX_W-1:0] REG_UNIT_BASE   = 1'd0;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_LC_K  = 8'h6B;
  localparam logic [CHAR_W-1:0] CH_UC_K  = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_LC_M  = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_UC_M  = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_LC_G  = 8'h67;
  localparam logic [CHAR_W-1:0] CH_UC_G  = 8'h47;
  localparam logic [CHAR_W-1:0] CH_LC_T  = 8'h74;
  localparam logic [CHAR_W-1:0] CH_UC_T  = 8'h54;
  localparam logic [CHAR_W-1:0] CH_LC_P  = 8'h70;
  localparam logic [CHAR_W-1:0] CH_UC_P  = 8'h50;
  localparam logic [CHAR_W-1:0] CH_LC_E  = 8'h65;
  localparam logic [CHAR_W-1:0] CH_UC_E  = 8'h45;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_SYNTAX   = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_SKIP   = 5'b00001,
    ST_SIGN   = 5'b00010,
    ST_DIGITS = 5'b00100,
    ST_DONE   = 5'b01000,
    ST_SCALE  = 5'b10000
  } state_e;

  typedef struct packed {
    logic               use_base;
    logic               neg;
    logic [DIGIT_W-1:0] digit;
  } alu_req_t;

  typedef struct packed {
    logic               ok;
    logic [SCALE_W-1:0] count;
  } expo_t;

  function automatic expo_t exponent_of(input logic [CHAR_W-1:0] c);
    expo_t r;
    r.ok    = 1'b1;
    r.count = 3'd0;
    case (c)
      CH_NUL, CH_SPACE, CH_TAB: r.count = 3'd0;
      CH_LC_K, CH_UC_K:         r.count = 3'd1;
      CH_LC_M, CH_UC_M:         r.count = 3'd2;
      CH_LC_G, CH_UC_G:         r.count = 3'd3;
      CH_LC_T, CH_UC_T:         r.count = 3'd4;
      CH_LC_P, CH_UC_P:         r.count = 3'd5;
      CH_LC_E, CH_UC_E:         r.count = 3'd6;
      default:                  r.ok    = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### sv/sizstr_if.sv
// Valid/ready channels of the size string converter: character in, result out.
// Depends on sizstr_pkg.
interface sizstr_in_if;
  logic                             valid;
  logic                             ready;
  logic [sizstr_pkg::CHAR_W-1:0]    char_code;
  logic                             end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface sizstr_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sizstr_pkg::OUT_W-1:0] value;
  logic [sizstr_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

### sv/sizstr_alu.sv
// Shared multiply-add unit: acc * (10 or unit base) +/- digit, with range check.
// Depends on sizstr_pkg.
module sizstr_alu #(
  parameter int VALUE_BITS = sizstr_pkg::VALUE_BITS_DEF
) (
  input  logic signed [VALUE_BITS-1:0]    acc_i,
  input  logic [sizstr_pkg::BASE_W-1:0]   base_i,
  input  sizstr_pkg::alu_req_t            req_i,
  output logic [VALUE_BITS-1:0]           res_o,
  output logic                            ovf_o
);

  localparam int MUL_W = sizstr_pkg::BASE_W + 1;
  localparam int PW    = VALUE_BITS + MUL_W;
  localparam int ADD_W = sizstr_pkg::DIGIT_W + 1;

  logic signed [MUL_W-1:0] mul;
  logic signed [ADD_W-1:0] add;
  logic signed [PW-1:0]    acc_x;
  logic signed [PW-1:0]    mul_x;
  logic signed [PW-1:0]    sum;
  logic [PW-VALUE_BITS:0]  top;

  always_comb begin
    mul = req_i.use_base ? $signed({1'b0, base_i}) : MUL_W'(sizstr_pkg::DEC_BASE);
    add = $signed({1'b0, req_i.digit});
    if (req_i.use_base) begin
      add = '0;
    end else if (req_i.neg) begin
      add = -add;
    end
    acc_x = PW'(acc_i);
    mul_x = PW'(mul);
    sum   = acc_x * mul_x + PW'(add);
    top   = sum[PW-1:VALUE_BITS-1];
    ovf_o = !((&top) || !(|top));
    res_o = sum[VALUE_BITS-1:0];
  end

endmodule

### sv/size_suffix_string_to_integer.sv
// Top level of the size string converter: parse sequencer, APB register, result beat.
// Depends on sizstr_pkg, sizstr_if and sizstr_alu.
//
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      char_code[7:0], end_of_string
//  out_o    out  valid/ready      value[63:0] signed, status[1:0]
//  apb      in   psel/penable     paddr[2:0], pwdata/prdata[31:0], pready tied high
//
// Blanks, signs and digits are taken as they arrive; a unit letter multiplies by the unit
// base once per suffix power (1 to 6) through the shared multiply-add unit, not ready meanwhile.
// Reset clears the parse state and sets unit_base to 1024; no clearing pass.
// A result beat the sink has not taken holds off every input beat and the suffix scaling.
module size_suffix_string_to_integer #(
  parameter int VALUE_BITS = sizstr_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sizstr_in_if.sink                          in_i,
  sizstr_out_if.source                       out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sizstr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sizstr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sizstr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                               pready
);

  sizstr_pkg::state_e                  state_q, state_d;
  logic                                neg_q, neg_d;
  logic signed [VALUE_BITS-1:0]        acc_q, acc_d;
  logic [sizstr_pkg::SCALE_W-1:0]      cnt_q, cnt_d;
  logic                                end_q, end_d;
  logic [sizstr_pkg::BASE_W-1:0]       base_q;
  logic                                out_valid_q;
  logic signed [sizstr_pkg::OUT_W-1:0] out_value_q;
  sizstr_pkg::status_e                 out_status_q;

  sizstr_pkg::alu_req_t                alu_req;
  logic [VALUE_BITS-1:0]               alu_res;
  logic                                alu_ovf;

  logic                                out_free;
  logic                                in_ready;
  logic                                in_fire;
  logic                                emit;
  logic [VALUE_BITS-1:0]               emit_val;
  sizstr_pkg::status_e                 emit_st;
  logic [sizstr_pkg::CHAR_W-1:0]       c;
  logic                                eos;
  logic                                is_digit;
  logic                                is_blank;
  logic                                is_sign;
  sizstr_pkg::expo_t                   expo;
  logic                                cfg_wr;

  sizstr_alu #(
    .VALUE_BITS(VALUE_BITS)
  ) u_alu (
    .acc_i (acc_q),
    .base_i(base_q),
    .req_i (alu_req),
    .res_o (alu_res),
    .ovf_o (alu_ovf)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = (state_q != sizstr_pkg::ST_SCALE) && out_free;
  assign in_fire  = in_i.valid && in_ready;
  assign c        = in_i.char_code;
  assign eos      = in_i.end_of_string;
  assign is_digit = (c >= sizstr_pkg::CH_ZERO) && (c <= sizstr_pkg::CH_NINE);
  assign is_blank = (c == sizstr_pkg::CH_SPACE) || (c == sizstr_pkg::CH_TAB);
  assign is_sign  = (c == sizstr_pkg::CH_PLUS) || (c == sizstr_pkg::CH_MINUS);
  assign expo     = sizstr_pkg::exponent_of(c);

  always_comb begin
    state_d        = state_q;
    neg_d          = neg_q;
    acc_d          = acc_q;
    cnt_d          = cnt_q;
    end_d          = end_q;
    emit           = 1'b0;
    emit_val       = '1;
    emit_st        = sizstr_pkg::STAT_SYNTAX;
    alu_req.use_base = 1'b0;
    alu_req.neg      = neg_q;
    alu_req.digit    = c[sizstr_pkg::DIGIT_W-1:0];
    case (state_q)
      sizstr_pkg::ST_SCALE: begin
        alu_req.use_base = 1'b1;
        if (out_free) begin
          if (alu_ovf) begin
            emit    = 1'b1;
            emit_st = sizstr_pkg::STAT_OVERFLOW;
          end else begin
            acc_d = alu_res;
            cnt_d = cnt_q - 3'd1;
            if (cnt_q == 3'd1) begin
              emit     = 1'b1;
              emit_val = alu_res;
              emit_st  = sizstr_pkg::STAT_OK;
            end
          end
          if (emit) begin
            if (end_q) begin
              state_d = sizstr_pkg::ST_SKIP;
              neg_d   = 1'b0;
              acc_d   = '0;
            end else begin
              state_d = sizstr_pkg::ST_DONE;
            end
          end
        end
      end
      sizstr_pkg::ST_SKIP, sizstr_pkg::ST_SIGN,
      sizstr_pkg::ST_DIGITS, sizstr_pkg::ST_DONE: begin
        if (in_fire) begin
          if (state_q == sizstr_pkg::ST_DONE) begin
            state_d = sizstr_pkg::ST_DONE;
          end else if (state_q == sizstr_pkg::ST_SKIP && is_blank) begin
            state_d = sizstr_pkg::ST_SKIP;
          end else if (state_q == sizstr_pkg::ST_SKIP && is_sign) begin
            neg_d   = (c == sizstr_pkg::CH_MINUS);
            state_d = sizstr_pkg::ST_SIGN;
          end else if (state_q != sizstr_pkg::ST_DIGITS) begin
            if (!is_digit) begin
              emit = 1'b1;
            end else if (alu_ovf) begin
              emit    = 1'b1;
              emit_st = sizstr_pkg::STAT_OVERFLOW;
            end else begin
              acc_d   = alu_res;
              state_d = sizstr_pkg::ST_DIGITS;
            end
          end else if (is_digit) begin
            if (alu_ovf) begin
              emit    = 1'b1;
              emit_st = sizstr_pkg::STAT_OVERFLOW;
            end else begin
              acc_d = alu_res;
            end
          end else if (expo.ok) begin
            if (expo.count == 3'd0) begin
              emit     = 1'b1;
              emit_val = acc_q;
              emit_st  = sizstr_pkg::STAT_OK;
            end else begin
              state_d = sizstr_pkg::ST_SCALE;
              cnt_d   = expo.count;
              end_d   = eos;
            end
          end else begin
            emit = 1'b1;
          end

          if (eos && !emit && state_d != sizstr_pkg::ST_SCALE) begin
            if (state_d == sizstr_pkg::ST_SKIP || state_d == sizstr_pkg::ST_SIGN) begin
              emit = 1'b1;
            end else if (state_d == sizstr_pkg::ST_DIGITS) begin
              emit     = 1'b1;
              emit_val = acc_d;
              emit_st  = sizstr_pkg::STAT_OK;
            end
          end

          if (emit) begin
            state_d = sizstr_pkg::ST_DONE;
          end

          if (eos && state_d != sizstr_pkg::ST_SCALE) begin
            state_d = sizstr_pkg::ST_SKIP;
            neg_d   = 1'b0;
            acc_d   = '0;
          end
        end
      end
      default: begin
        state_d = sizstr_pkg::ST_SKIP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sizstr_pkg::ST_SKIP;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      end_q   <= end_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q  <= sizstr_pkg::OUT_W'($signed(emit_val));
      out_status_q <= emit_st;
    end
  end

  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[sizstr_pkg::APB_ADDR_W-1:2] == sizstr_pkg::REG_UNIT_BASE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= sizstr_pkg::UNIT_BASE_RESET;
    end else if (cfg_wr) begin
      base_q <= pwdata[sizstr_pkg::BASE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[sizstr_pkg::APB_ADDR_W-1:2] == sizstr_pkg::REG_UNIT_BASE) begin
      prdata = sizstr_pkg::APB_DATA_W'(base_q);
    end
  end

  assign pready       = 1'b1;
  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

endmodule

### sv/sizstr_chk.sv
// Port-level checks for the size string converter, bound to the top level.
// Depends on sizstr_pkg.
module sizstr_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [sizstr_pkg::OUT_W-1:0]        out_value_i,
  input logic [sizstr_pkg::STATUS_W-1:0]     out_status_i,
  input logic                                psel_i,
  input logic                                penable_i,
  input logic                                pwrite_i,
  input logic [sizstr_pkg::APB_ADDR_W-1:0]   paddr_i,
  input logic [sizstr_pkg::APB_DATA_W-1:0]   pwdata_i,
  input logic [sizstr_pkg::APB_DATA_W-1:0]   prdata_i
);

  logic wr_base;
  logic rd_base;

  assign wr_base = psel_i && penable_i && pwrite_i &&
                   (paddr_i[sizstr_pkg::APB_ADDR_W-1:2] == sizstr_pkg::REG_UNIT_BASE);
  assign rd_base = psel_i && !pwrite_i &&
                   (paddr_i[sizstr_pkg::APB_ADDR_W-1:2] == sizstr_pkg::REG_UNIT_BASE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) &&
                                    $stable(out_status_i))
    else $error("result beat dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == sizstr_pkg::STAT_OK ||
                    out_status_i == sizstr_pkg::STAT_SYNTAX ||
                    out_status_i == sizstr_pkg::STAT_OVERFLOW)
    else $error("undefined status code");

  a_error_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != sizstr_pkg::STAT_OK |-> &out_value_i)
    else $error("error beat without value -1");

  a_base_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_base ##1 rd_base |->
      prdata_i[sizstr_pkg::BASE_W-1:0] == $past(pwdata_i[sizstr_pkg::BASE_W-1:0]))
    else $error("unit_base readback mismatch");

endmodule

bind size_suffix_string_to_integer sizstr_chk u_sizstr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_status_i(out_o.status),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata)
);

### tb/tb.sv
// Testbench for size_suffix_string_to_integer: streams size strings one character per beat,
// predicts each parsed value and status, and compares every result beat in order.
// Depends on sizstr_pkg, sizstr_in_if, sizstr_out_if and the converter RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {PH_SKIP, PH_SIGN, PH_DIGITS, PH_DONE} parse_phase_e;

  typedef struct packed {
    logic [sizstr_pkg::CHAR_W-1:0] code;
    logic                          eos;
  } char_beat_t;

  typedef struct packed {
    logic signed [sizstr_pkg::OUT_W-1:0] value;
    sizstr_pkg::status_e                 status;
  } size_result_t;

  localparam longint VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint VAL_MIN = -VAL_MAX - 1;
  localparam logic [sizstr_pkg::APB_ADDR_W-1:0] UNIT_BASE_ADDR =
    {sizstr_pkg::REG_UNIT_BASE, 2'b00};
  localparam logic [sizstr_pkg::APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam int IDLE_PCT = 23;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int SETTLE_CYCLES = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [sizstr_pkg::APB_ADDR_W-1:0] paddr;
  logic [sizstr_pkg::APB_DATA_W-1:0] pwdata;
  logic [sizstr_pkg::APB_DATA_W-1:0] prdata;
  logic                              pready;

  sizstr_in_if  in_ch ();
  sizstr_out_if out_ch ();

  size_suffix_string_to_integer DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  char_beat_t   pending_chars[$];
  size_result_t parsed_q[$];
  int           chars_queued = 0;
  int           chars_taken = 0;
  int           mismatches = 0;
  logic         calm = 1'b0;
  logic         rx_block = 1'b0;
  logic         squeeze_go = 1'b0;

  parse_phase_e                  ph = PH_SKIP;
  logic                          neg = 1'b0;
  longint                        acc = 0;
  logic [sizstr_pkg::BASE_W-1:0] unit_base_cfg = sizstr_pkg::UNIT_BASE_RESET;

  logic [sizstr_pkg::CHAR_W-1:0] unit_chars[12] = '{
    sizstr_pkg::CH_LC_K, sizstr_pkg::CH_UC_K, sizstr_pkg::CH_LC_M, sizstr_pkg::CH_UC_M,
    sizstr_pkg::CH_LC_G, sizstr_pkg::CH_UC_G, sizstr_pkg::CH_LC_T, sizstr_pkg::CH_UC_T,
    sizstr_pkg::CH_LC_P, sizstr_pkg::CH_UC_P, sizstr_pkg::CH_LC_E, sizstr_pkg::CH_UC_E};
  logic [sizstr_pkg::CHAR_W-1:0] term_chars[3] = '{
    sizstr_pkg::CH_SPACE, sizstr_pkg::CH_TAB, sizstr_pkg::CH_NUL};

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int give_result(input longint v, input sizstr_pkg::status_e s);
    size_result_t r;
    r.value  = v;
    r.status = s;
    parsed_q.push_back(r);
    ph = PH_DONE;
    return 1;
  endfunction

  function automatic bit take_digit(input logic [sizstr_pkg::CHAR_W-1:0] c);
    longint d;
    longint x;
    d = c - sizstr_pkg::CH_ZERO;
    x = acc;
    if (x > VAL_MAX / sizstr_pkg::DEC_BASE || x < VAL_MIN / sizstr_pkg::DEC_BASE) return 1'b0;
    x = x * sizstr_pkg::DEC_BASE;
    if (neg) begin
      if (x < VAL_MIN + d) return 1'b0;
      x = x - d;
    end else begin
      if (x > VAL_MAX - d) return 1'b0;
      x = x + d;
    end
    acc = x;
    return 1'b1;
  endfunction

  function automatic int unit_powers(input logic [sizstr_pkg::CHAR_W-1:0] c);
    case (c)
      sizstr_pkg::CH_NUL, sizstr_pkg::CH_SPACE, sizstr_pkg::CH_TAB: return 0;
      sizstr_pkg::CH_LC_K, sizstr_pkg::CH_UC_K: return 1;
      sizstr_pkg::CH_LC_M, sizstr_pkg::CH_UC_M: return 2;
      sizstr_pkg::CH_LC_G, sizstr_pkg::CH_UC_G: return 3;
      sizstr_pkg::CH_LC_T, sizstr_pkg::CH_UC_T: return 4;
      sizstr_pkg::CH_LC_P, sizstr_pkg::CH_UC_P: return 5;
      sizstr_pkg::CH_LC_E, sizstr_pkg::CH_UC_E: return 6;
      default: return -1;
    endcase
  endfunction

  function automatic int parse_char(input logic [sizstr_pkg::CHAR_W-1:0] c);
    bit     digit;
    int     powers;
    longint b;
    digit = (c >= sizstr_pkg::CH_ZERO && c <= sizstr_pkg::CH_NINE);
    if (ph == PH_DONE) return 0;
    if (ph == PH_SKIP) begin
      if (c == sizstr_pkg::CH_SPACE || c == sizstr_pkg::CH_TAB) return 0;
      if (c == sizstr_pkg::CH_MINUS || c == sizstr_pkg::CH_PLUS) begin
        neg = (c == sizstr_pkg::CH_MINUS);
        ph = PH_SIGN;
        return 0;
      end
      ph = PH_SIGN;
    end
    if (ph == PH_SIGN) begin
      if (!digit) return give_result(-1, sizstr_pkg::STAT_SYNTAX);
      if (!take_digit(c)) return give_result(-1, sizstr_pkg::STAT_OVERFLOW);
      ph = PH_DIGITS;
      return 0;
    end
    if (digit) begin
      if (!take_digit(c)) return give_result(-1, sizstr_pkg::STAT_OVERFLOW);
      return 0;
    end
    powers = unit_powers(c);
    if (powers < 0) return give_result(-1, sizstr_pkg::STAT_SYNTAX);
    b = unit_base_cfg;
    repeat (powers) begin
      if (b != 0 && acc > 0 && acc > VAL_MAX / b)
        return give_result(-1, sizstr_pkg::STAT_OVERFLOW);
      if (b != 0 && acc < 0 && acc < VAL_MIN / b)
        return give_result(-1, sizstr_pkg::STAT_OVERFLOW);
      acc = acc * b;
    end
    return give_result(acc, sizstr_pkg::STAT_OK);
  endfunction

  function automatic void size_step(input logic [sizstr_pkg::CHAR_W-1:0] c, input logic eos);
    int n;
    n = parse_char(c);
    if (n == 0 && eos) n = parse_char(sizstr_pkg::CH_NUL);
    if (eos) begin
      ph  = PH_SKIP;
      neg = 1'b0;
      acc = 0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : char_driver
    char_beat_t nxt;
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.char_code     <= '0;
      in_ch.end_of_string <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        chars_taken++;
        size_step(in_ch.char_code, in_ch.end_of_string);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_chars.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_chars.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.char_code     <= nxt.code;
          in_ch.end_of_string <= nxt.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_block && (calm || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    size_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (parsed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result value %0d status %0d",
                                out_ch.value, out_ch.status));
      end else begin
        want = parsed_q.pop_front();
        if (out_ch.value !== want.value)
          flag_mismatch($sformatf("value %0d, predicted %0d", out_ch.value,
                                  $signed(want.value)));
        if (out_ch.status !== want.status)
          flag_mismatch($sformatf("status %0d, predicted %0d", out_ch.status, want.status));
      end
    end
  end

  // hold off the result side for a long stretch once triggered
  initial begin
    wait (squeeze_go);
    @(posedge clk_i);
    rx_block <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk_i);
    rx_block <= 1'b0;
  end

  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_byte(input logic [sizstr_pkg::CHAR_W-1:0] c, input logic eos);
    char_beat_t b;
    b.code = c;
    b.eos  = eos;
    pending_chars.push_back(b);
    chars_queued++;
  endtask

  task automatic push_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], close && i == s.len() - 1);
  endtask

  task automatic gen_string();
    logic [sizstr_pkg::CHAR_W-1:0] txt[$];
    string                         lim;
    int                            kind;
    int                            n;
    lim  = "922337203685477580";
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2))
      txt.push_back($urandom_range(0, 1) ? sizstr_pkg::CH_SPACE : sizstr_pkg::CH_TAB);
    if (kind < 20) begin
      repeat ($urandom_range(1, 8)) txt.push_back(sizstr_pkg::CHAR_W'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 2))
        1: txt.push_back(sizstr_pkg::CH_PLUS);
        2: txt.push_back(sizstr_pkg::CH_MINUS);
        default: ;
      endcase
      if (kind < 32) begin
        txt.push_back(sizstr_pkg::CHAR_W'($urandom_range(0, 255)));
      end else if (kind < 44) begin
        for (int i = 0; i < lim.len(); i++) txt.push_back(lim[i]);
        txt.push_back(sizstr_pkg::CH_ZERO + sizstr_pkg::CHAR_W'($urandom_range(5, 9)));
      end else begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 21) : $urandom_range(1, 5);
        repeat (n)
          txt.push_back(sizstr_pkg::CH_ZERO + sizstr_pkg::CHAR_W'($urandom_range(0, 9)));
      end
      case ($urandom_range(0, 3))
        0: ;
        1: txt.push_back(term_chars[$urandom_range(0, 2)]);
        default: txt.push_back(unit_chars[$urandom_range(0, 11)]);
      endcase
      repeat ($urandom_range(0, 2)) txt.push_back(sizstr_pkg::CHAR_W'($urandom_range(0, 255)));
    end
    foreach (txt[i]) push_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic drain();
    while (chars_taken != chars_queued || parsed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [sizstr_pkg::APB_ADDR_W-1:0] a,
                           input logic [sizstr_pkg::BASE_W-1:0] d);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= {{(sizstr_pkg::APB_DATA_W - sizstr_pkg::BASE_W){1'b0}}, d};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == UNIT_BASE_ADDR) unit_base_cfg = d;
  endtask

  task automatic check_base();
    logic [sizstr_pkg::APB_DATA_W-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= UNIT_BASE_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== {{(sizstr_pkg::APB_DATA_W - sizstr_pkg::BASE_W){1'b0}}, unit_base_cfg})
      flag_mismatch($sformatf("unit_base read %0d, predicted %0d", got, unit_base_cfg));
  endtask

  task automatic run_strings(input int len);
    int start;
    start = chars_queued;
    while (chars_queued - start < len) gen_string();
  endtask

  initial begin : stimulus
    logic [sizstr_pkg::BASE_W-1:0] bases[6];
    int                            lens[6];
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    bases = '{16'd1000, 16'd1, 16'hFFFF, 16'd0,
              sizstr_pkg::BASE_W'($urandom_range(2, 65534)),
              sizstr_pkg::BASE_W'($urandom_range(2, 65534))};
    lens  = '{180, 180, 180, 60, 140, 140};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    check_base();
    push_text(" -7k", 1'b1);
    push_byte(sizstr_pkg::CH_PLUS, 1'b1);
    push_byte(sizstr_pkg::CH_TAB, 1'b0);
    push_byte(sizstr_pkg::CH_SPACE, 1'b1);
    push_text("5", 1'b0);
    push_byte(sizstr_pkg::CH_NUL, 1'b0);
    push_text("x", 1'b1);
    push_text("3q", 1'b1);
    push_text("- 1", 1'b1);
    push_byte(8'hFF, 1'b1);
    push_text("9E", 1'b1);
    push_text("12", 1'b1);
    push_byte(sizstr_pkg::CH_NUL, 1'b1);
    run_strings(150);
    drain();

    // writes beyond the register list leave unit_base alone
    reg_write(SPARE_ADDR, sizstr_pkg::BASE_W'($urandom_range(0, 65535)));
    check_base();

    for (int p = 0; p < 6; p++) begin
      reg_write(UNIT_BASE_ADDR, bases[p]);
      check_base();
      if (p == 0) squeeze_go <= 1'b1;
      if (p == 2) calm <= 1'b1;
      run_strings(lens[p]);
      drain();
      calm <= 1'b0;
    end

    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

### size_suffix_string_to_integer.f
sv/sizstr_pkg.sv
sv/sizstr_if.sv
sv/sizstr_alu.sv
sv/size_suffix_string_to_integer.sv
sv/sizstr_chk.sv
tb/tb.sv
